// File: hdl/nsdt_pkg.sv
`timescale 1ns / 1ps

package nsdt_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int NAME_CHARS_DEF = 8;
	localparam int ENTRIES_MAX    = 256;
	localparam int SLOT_W         = $clog2(ENTRIES_MAX);

	localparam int FUNC_W      = 2;
	localparam int FILE_NAME_W = 64;
	localparam int SECTOR_W    = 16;
	localparam int STATUS_W    = 2;
	localparam int INDEX_W     = 4;

	localparam logic [FUNC_W-1:0] FN_FIND   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic                   vld;
		logic [FUNC_W-1:0]      func;
		logic [FILE_NAME_W-1:0] key;
		logic [SECTOR_W-1:0]    sector;
		logic                   hit;
		slot_t                  hit_idx;
		logic [SECTOR_W-1:0]    hit_sector;
		logic                   free;
		slot_t                  free_idx;
	} req_t;

	typedef struct packed {
		logic                   set;
		logic                   clr;
		slot_t                  idx;
		logic [FILE_NAME_W-1:0] name;
		logic [SECTOR_W-1:0]    sector;
	} wr_t;

endpackage

// File: hdl/nsdt_cell.sv
`timescale 1ns / 1ps

module nsdt_cell #(
	parameter int NAME_W = 64,
	parameter int SLOT   = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  nsdt_pkg::req_t  req_in,
	output nsdt_pkg::req_t  req_out,
	input  nsdt_pkg::wr_t   wr
);
	import nsdt_pkg::*;

	localparam slot_t SLOT_ID = slot_t'(SLOT);

	logic                valid_q;
	logic [NAME_W-1:0]   name_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                match;
	logic                sel;
	req_t                nxt;
	req_t                req_q;

	assign match = valid_q && (name_q == req_in.key[NAME_W-1:0]);
	assign sel   = (wr.idx == SLOT_ID);

	always_comb begin
		nxt = req_in;
		if (!req_in.hit && match) begin
			nxt.hit        = 1'b1;
			nxt.hit_idx    = SLOT_ID;
			nxt.hit_sector = sector_q;
		end
		if (!req_in.free && !valid_q) begin
			nxt.free     = 1'b1;
			nxt.free_idx = SLOT_ID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
		end else begin
			req_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.set && sel) begin
			valid_q <= 1'b1;
		end else if (wr.clr && sel) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.set && sel) begin
			name_q   <= wr.name[NAME_W-1:0];
			sector_q <= wr.sector;
		end
	end

	assign req_out = req_q;

endmodule

// File: hdl/name_to_sector_directory_table.sv
`timescale 1ns / 1ps

// A small associative directory of up to ENTRIES names, each mapped to a header sector.
// A request is taken at a rising edge where start is high and busy is low; it carries
// func (find, add or remove), file_name and header_sector. Only the low NAME_CHARS bytes
// of the name are compared, every one of them.
// The request walks down a row of ENTRIES cells, one cell per cycle, each cell holding one
// entry and noting the first match and the first free slot. When it leaves the last cell
// the result is registered, and any add or remove is written back on the same edge.
// The request passes from the head register through each cell register to the result
// registers. The result is on status, found_sector and entry_index, marked by done for
// exactly one cycle. The receiver cannot stall the block, so the result must be taken in
// that cycle.
// One request is handled at a time; busy is high during the walk, and the next request may
// be taken in the cycle where done is high.
// Reset clears every valid mark and any request in flight; stored names and sectors are
// left as they are and are never read until written.
module name_to_sector_directory_table #(
	parameter int ENTRIES    = nsdt_pkg::ENTRIES_DEF,
	parameter int NAME_CHARS = nsdt_pkg::NAME_CHARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [nsdt_pkg::FUNC_W-1:0]      func,
	input  logic [nsdt_pkg::FILE_NAME_W-1:0] file_name,
	input  logic [nsdt_pkg::SECTOR_W-1:0]    header_sector,
	output logic                             done,
	output logic [nsdt_pkg::STATUS_W-1:0]    status,
	output logic [nsdt_pkg::SECTOR_W-1:0]    found_sector,
	output logic [nsdt_pkg::INDEX_W-1:0]     entry_index
);
	import nsdt_pkg::*;

	localparam int NAME_W = 8 * NAME_CHARS;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t              state_q;
	logic                accept;
	req_t                head_q;
	req_t                chain [ENTRIES+1];
	req_t                tail;
	wr_t                 wr;
	logic [STATUS_W-1:0] res_status;
	logic [SECTOR_W-1:0] res_sector;
	slot_t               res_idx;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SECTOR_W-1:0] found_sector_q;
	logic [INDEX_W-1:0]  entry_index_q;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q == S_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tail.vld) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q.vld        <= accept;
			head_q.func       <= func;
			head_q.key        <= FILE_NAME_W'(file_name[NAME_W-1:0]);
			head_q.sector     <= header_sector;
			head_q.hit        <= 1'b0;
			head_q.hit_idx    <= '0;
			head_q.hit_sector <= '0;
			head_q.free       <= 1'b0;
			head_q.free_idx   <= '0;
		end
	end

	assign chain[0] = head_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		nsdt_cell #(
			.NAME_W (NAME_W),
			.SLOT   (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req_in  (chain[i]),
			.req_out (chain[i+1]),
			.wr      (wr)
		);
	end

	assign tail = chain[ENTRIES];

	always_comb begin
		res_status = ST_NOT_FOUND;
		res_sector = '0;
		res_idx    = '0;
		wr         = '0;
		wr.name    = tail.key;
		wr.sector  = tail.sector;
		unique case (tail.func)
			FN_FIND: begin
				if (tail.hit) begin
					res_status = ST_OK;
					res_sector = tail.hit_sector;
					res_idx    = tail.hit_idx;
				end
			end
			FN_ADD: begin
				if (tail.hit) begin
					res_status = ST_PRESENT;
				end else if (tail.free) begin
					res_status = ST_OK;
					res_idx    = tail.free_idx;
					wr.set     = tail.vld;
					wr.idx     = tail.free_idx;
				end else begin
					res_status = ST_FULL;
				end
			end
			FN_REMOVE: begin
				if (tail.hit) begin
					res_status = ST_OK;
					res_idx    = tail.hit_idx;
					wr.clr     = tail.vld;
					wr.idx     = tail.hit_idx;
				end
			end
			default: begin
				res_status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.vld) begin
			status_q       <= res_status;
			found_sector_q <= res_sector;
			entry_index_q  <= res_idx[INDEX_W-1:0];
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign found_sector = found_sector_q;
	assign entry_index  = entry_index_q;

endmodule
